[rtl/rsfr_pkg.sv]
package rsfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'h02;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_GOT_FF,
        PH_ROBOT,
        PH_FLAGS,
        PH_CHNUM,
        PH_CHCNT
    } t_phase;

    // Status word: [15:12] flag byte bits 6..3, [11:4] change number, [3:0] change count.
    typedef struct packed {
        logic        do_write;
        logic [3:0]  idx;
        logic [15:0] word;
        logic        do_report;
    } t_cmd;

endpackage

[rtl/rsfr_front.sv]
module rsfr_front #(
    parameter int ROBOT_COUNT = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_push,
    output rsfr_pkg::t_cmd      o_cmd
);

    rsfr_pkg::t_phase r_phase, n_phase;
    logic [3:0] r_robot, n_robot;
    logic [3:0] r_flags, n_flags;
    logic [7:0] r_chnum, n_chnum;
    logic       r_done, n_done;
    logic       accept;
    logic [3:0] nib;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign nib     = i_byte[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsfr_pkg::PH_HUNT;
            r_robot <= '0;
            r_flags <= '0;
            r_chnum <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_robot <= n_robot;
            r_flags <= n_flags;
            r_chnum <= n_chnum;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_robot         = r_robot;
        n_flags         = r_flags;
        n_chnum         = r_chnum;
        n_done          = r_done;
        o_cmd.do_write  = 1'b0;
        o_cmd.idx       = r_robot - 4'd1;
        o_cmd.word      = {r_flags, r_chnum, nib};
        o_cmd.do_report = i_last;
        if (accept && !r_done) begin
            case (r_phase)
                rsfr_pkg::PH_HUNT: begin
                    if (i_byte == rsfr_pkg::HDR_FIRST) begin
                        n_phase = rsfr_pkg::PH_GOT_FF;
                    end
                end
                rsfr_pkg::PH_GOT_FF: begin
                    if (i_byte == rsfr_pkg::HDR_SECOND) begin
                        n_phase = rsfr_pkg::PH_ROBOT;
                    end else if (i_byte != rsfr_pkg::HDR_FIRST) begin
                        n_phase = rsfr_pkg::PH_HUNT;
                    end
                end
                rsfr_pkg::PH_ROBOT: begin
                    if (nib == 4'd0 || nib > 4'(ROBOT_COUNT)) begin
                        n_done  = 1'b1;
                        n_phase = rsfr_pkg::PH_HUNT;
                    end else begin
                        n_robot = nib;
                        n_phase = rsfr_pkg::PH_FLAGS;
                    end
                end
                rsfr_pkg::PH_FLAGS: begin
                    n_flags = i_byte[6:3];
                    n_phase = rsfr_pkg::PH_CHNUM;
                end
                rsfr_pkg::PH_CHNUM: begin
                    n_chnum = i_byte;
                    n_phase = rsfr_pkg::PH_CHCNT;
                end
                rsfr_pkg::PH_CHCNT: begin
                    o_cmd.do_write = 1'b1;
                    n_done         = 1'b1;
                    n_phase        = rsfr_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = rsfr_pkg::PH_HUNT;
                end
            endcase
        end
        if (accept && i_last) begin
            n_phase = rsfr_pkg::PH_HUNT;
            n_done  = 1'b0;
        end
        o_push = accept && (o_cmd.do_write || i_last);
    end

endmodule

[rtl/rsfr_queue.sv]
module rsfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsfr_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output rsfr_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    rsfr_pkg::t_cmd r_mem [rsfr_pkg::QUEUE_DEPTH];
    logic [rsfr_pkg::QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [rsfr_pkg::QUEUE_CNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = r_cnt == rsfr_pkg::QUEUE_CNT_W'(rsfr_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/rsfr_back.sv]
module rsfr_back #(
    parameter int ROBOT_COUNT = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  rsfr_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [23:0]    o_data,
    output logic           o_last
);

    localparam int IDX_W = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;

    logic [15:0]      r_table [ROBOT_COUNT];
    logic             r_busy;
    logic [IDX_W-1:0] r_cnt;
    logic             r_valid;
    logic [23:0]      r_data;
    logic             r_last;
    logic             load;
    logic             at_end;
    logic [15:0]      w;
    logic [3:0]       robot;

    assign o_pop   = i_q_valid && !r_busy;
    assign load    = r_busy && (!r_valid || i_ready);
    assign at_end  = r_cnt == IDX_W'(ROBOT_COUNT - 1);
    assign w       = r_table[r_cnt];
    assign robot   = 4'(r_cnt) + 4'd1;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROBOT_COUNT; k++) begin
                r_table[k] <= '0;
            end
        end else if (o_pop && i_cmd.do_write) begin
            r_table[i_cmd.idx[IDX_W-1:0]] <= i_cmd.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop && i_cmd.do_report) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (load) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= {4'd0, w[3:0], w[11:4], w[12], w[13], w[14], w[15], robot};
            r_last <= at_end;
        end
    end

endmodule

[rtl/robot_status_frame_receiver.sv]
// Accepts one byte per cycle while the two-entry command queue has room.
// A chunk end passes through the command queue to the report stage, which then gives
// ROBOT_COUNT results, one per cycle unless stalled, via the single table read port.
// Bytes keep flowing during a report until the queue fills behind it.
// Synchronous active-low reset clears the parser, the queue and the status table.
module robot_status_frame_receiver #(
    parameter int ROBOT_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // robot_number[3:0], infrared_seen[4], flat_kick_done[5], chip_kick_done[6],
    // under_control[7], change_number[15:8], change_count[19:16], zero[23:20]
    output logic [23:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic           push, full, q_valid, pop;
    rsfr_pkg::t_cmd front_cmd, head_cmd;

    rsfr_front #(.ROBOT_COUNT(ROBOT_COUNT)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    rsfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    rsfr_back #(.ROBOT_COUNT(ROBOT_COUNT)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

[test/robot_status_frame_receiver_checker.sv]
`timescale 1ns / 1ps

module robot_status_frame_receiver_checker #(
    parameter int ROBOT_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // rx_byte[7:0]
    input  logic [7:0]  i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // robot_number[3:0], infrared_seen[4], flat_kick_done[5], chip_kick_done[6],
    // under_control[7], change_number[15:8], change_count[19:16], zero[23:20]
    input  logic [23:0] i_m_axis_tdata,
    input  logic        i_m_axis_tlast,
    output int          o_mismatch_count,
    output int          o_reports_outstanding
);

    typedef struct {
        logic [3:0] robot;
        logic       infrared;
        logic       flat_flag;
        logic       chip_flag;
        logic       controlled;
        logic [7:0] change_number;
        logic [3:0] change_count;
        logic       last;
    } t_robot_report;

    rsfr_pkg::t_phase parse_phase;
    logic [3:0]       frame_robot;
    logic [7:0]       frame_flags;
    logic [7:0]       frame_change_number;
    logic             chunk_done;
    logic [15:0]      status_table [ROBOT_COUNT];
    t_robot_report    pending_reports [$];
    t_robot_report    want;
    int               mismatch_count = 0;

    initial begin
        o_mismatch_count      = 0;
        o_reports_outstanding = 0;
    end

    task automatic clear_receiver();
        parse_phase         = rsfr_pkg::PH_HUNT;
        frame_robot         = '0;
        frame_flags         = '0;
        frame_change_number = '0;
        chunk_done          = 1'b0;
        for (int k = 0; k < ROBOT_COUNT; k++) begin
            status_table[k] = '0;
        end
        pending_reports.delete();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        if (!chunk_done) begin
            case (parse_phase)
                rsfr_pkg::PH_HUNT: begin
                    if (b == rsfr_pkg::HDR_FIRST) parse_phase = rsfr_pkg::PH_GOT_FF;
                end
                rsfr_pkg::PH_GOT_FF: begin
                    if (b == rsfr_pkg::HDR_SECOND) parse_phase = rsfr_pkg::PH_ROBOT;
                    else if (b != rsfr_pkg::HDR_FIRST) parse_phase = rsfr_pkg::PH_HUNT;
                end
                rsfr_pkg::PH_ROBOT: begin
                    if (b[3:0] == 4'd0 || b[3:0] > ROBOT_COUNT) begin
                        chunk_done  = 1'b1;
                        parse_phase = rsfr_pkg::PH_HUNT;
                    end else begin
                        frame_robot = b[3:0];
                        parse_phase = rsfr_pkg::PH_FLAGS;
                    end
                end
                rsfr_pkg::PH_FLAGS: begin
                    frame_flags = b;
                    parse_phase = rsfr_pkg::PH_CHNUM;
                end
                rsfr_pkg::PH_CHNUM: begin
                    frame_change_number = b;
                    parse_phase         = rsfr_pkg::PH_CHCNT;
                end
                rsfr_pkg::PH_CHCNT: begin
                    status_table[frame_robot - 1] = {frame_flags[6:3], frame_change_number, b[3:0]};
                    chunk_done  = 1'b1;
                    parse_phase = rsfr_pkg::PH_HUNT;
                end
                default: begin
                    parse_phase = rsfr_pkg::PH_HUNT;
                end
            endcase
        end
    endtask

    task automatic queue_status_report();
        t_robot_report r;
        for (int k = 0; k < ROBOT_COUNT; k++) begin
            r.robot         = 4'(k + 1);
            r.infrared      = status_table[k][15];
            r.flat_flag     = status_table[k][14];
            r.chip_flag     = status_table[k][13];
            r.controlled    = status_table[k][12];
            r.change_number = status_table[k][11:4];
            r.change_count  = status_table[k][3:0];
            r.last          = (k == ROBOT_COUNT - 1);
            pending_reports.push_back(r);
        end
        parse_phase = rsfr_pkg::PH_HUNT;
        chunk_done  = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_receiver();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got tdata %h tlast %b",
                             $time, i_m_axis_tdata, i_m_axis_tlast);
                    mismatch_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("robot_number", 8'(want.robot), 8'(i_m_axis_tdata[3:0]));
                    check_field("infrared_seen", 8'(want.infrared), 8'(i_m_axis_tdata[4]));
                    check_field("flat_kick_done", 8'(want.flat_flag), 8'(i_m_axis_tdata[5]));
                    check_field("chip_kick_done", 8'(want.chip_flag), 8'(i_m_axis_tdata[6]));
                    check_field("under_control", 8'(want.controlled), 8'(i_m_axis_tdata[7]));
                    check_field("change_number", want.change_number, i_m_axis_tdata[15:8]);
                    check_field("change_count", 8'(want.change_count),
                                8'(i_m_axis_tdata[19:16]));
                    check_field("padding", 8'd0, 8'(i_m_axis_tdata[23:20]));
                    check_field("report_last", 8'(want.last), 8'(i_m_axis_tlast));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_byte(i_s_axis_tdata);
                if (i_s_axis_tlast) queue_status_report();
            end
        end
        o_mismatch_count      <= mismatch_count;
        o_reports_outstanding <= pending_reports.size();
    end

endmodule

[test/robot_status_frame_receiver_test.sv]
`timescale 1ns / 1ps

module robot_status_frame_receiver_test;

    localparam int ROBOT_COUNT = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // rx_byte[7:0]
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // robot_number[3:0], infrared_seen[4], flat_kick_done[5], chip_kick_done[6],
    // under_control[7], change_number[15:8], change_count[19:16], zero[23:20]
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    int          mismatch_count;
    int          reports_outstanding;

    logic [7:0]  chunk_bytes [$];
    int          bytes_sent = 0;
    int          ready_hold = 0;

    robot_status_frame_receiver #(
        .ROBOT_COUNT(ROBOT_COUNT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    robot_status_frame_receiver_checker #(
        .ROBOT_COUNT(ROBOT_COUNT)
    ) status_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_s_axis_tvalid      (i_s_axis_tvalid),
        .i_s_axis_tready      (o_s_axis_tready),
        .i_s_axis_tdata       (i_s_axis_tdata),
        .i_s_axis_tlast       (i_s_axis_tlast),
        .i_m_axis_tvalid      (o_m_axis_tvalid),
        .i_m_axis_tready      (i_m_axis_tready),
        .i_m_axis_tdata       (o_m_axis_tdata),
        .i_m_axis_tlast       (o_m_axis_tlast),
        .o_mismatch_count     (mismatch_count),
        .o_reports_outstanding(reports_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // The receiver mostly accepts results, with short and occasional long stalls.
    always @(posedge i_clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                i_m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(40, 150);
            end else if (r < 65) begin
                i_m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 8);
            end else if (r < 92) begin
                i_m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(10, 30);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return rsfr_pkg::HDR_FIRST;
        if (r < 30) return rsfr_pkg::HDR_SECOND;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit burst);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_chunk(input bit burst);
        for (int k = 0; k < chunk_bytes.size(); k++) begin
            send_byte(chunk_bytes[k], k == chunk_bytes.size() - 1, burst);
        end
    endtask

    task automatic drain_reports();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (reports_outstanding != 0);
    endtask

    task automatic push_frame();
        logic [3:0] low;
        int k;
        if ($urandom_range(0, 4) == 0) chunk_bytes.push_back(rsfr_pkg::HDR_FIRST);
        chunk_bytes.push_back(rsfr_pkg::HDR_FIRST);
        chunk_bytes.push_back(rsfr_pkg::HDR_SECOND);
        if ($urandom_range(0, 99) < 85) begin
            low = 4'($urandom_range(1, ROBOT_COUNT));
        end else begin
            k = $urandom_range(0, 3);
            low = (k == 0) ? 4'd0 : 4'(ROBOT_COUNT + k);
        end
        chunk_bytes.push_back({4'($urandom_range(0, 15)), low});
        repeat (3) chunk_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_chunk();
        int keep;
        chunk_bytes.delete();
        repeat ($urandom_range(0, 3)) chunk_bytes.push_back(noise_byte());
        if ($urandom_range(0, 9) < 8) begin
            push_frame();
            repeat ($urandom_range(0, 3)) chunk_bytes.push_back(noise_byte());
            if ($urandom_range(0, 4) == 0) push_frame();
        end
        if (chunk_bytes.size() == 0) chunk_bytes.push_back(noise_byte());
        if ($urandom_range(0, 99) < 15) begin
            keep = $urandom_range(1, chunk_bytes.size());
            while (chunk_bytes.size() > keep) void'(chunk_bytes.pop_back());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        i_m_axis_tready <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Chunk end with nothing received reports the cleared table.
        chunk_bytes = '{8'h00};
        send_chunk(1'b0);
        // Robot 1 with every flag set and the largest change number and count.
        chunk_bytes = '{8'hFF, 8'h02, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h12};
        send_chunk(1'b1);
        // Repeated header byte, robot 12, sixth frame byte ending the chunk.
        chunk_bytes = '{8'hFF, 8'hFF, 8'h02, 8'hFC, 8'h00, 8'h00, 8'h30};
        send_chunk(1'b0);
        // An out-of-range robot stops the search, so the later frame is ignored.
        chunk_bytes = '{8'hFF, 8'h02, 8'h0D, 8'hFF, 8'h02, 8'h05, 8'h08, 8'h11, 8'h22, 8'h33};
        send_chunk(1'b0);
        // A frame cut off by the chunk end is dropped.
        chunk_bytes = '{8'hFF, 8'h02, 8'h07, 8'h40};
        send_chunk(1'b1);
        drain_reports();

        while (bytes_sent < 170) begin
            build_random_chunk();
            send_chunk($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) drain_reports();
        end
        i_s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (reports_outstanding != 0);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
